### src/percent_decode_stream_assert.svh
`ifndef PERCENT_DECODE_STREAM_ASSERT_SVH
`define PERCENT_DECODE_STREAM_ASSERT_SVH

// concurrent check on aclk, off while reset is held
`define PDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// concurrent check on aclk that also runs during reset
`define PDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### src/pds_pkg.sv
package pds_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] NINE_CHAR  = 8'h39;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] HEX_TEN    = 8'd10;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_START = 3'b010,
        PH_DIGIT = 3'b100
    } pds_phase_t;

    typedef struct packed {
        pds_phase_t  phase;
        logic [7:0]  held;
    } pds_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } pds_result_t;

    // hex digit value with 8-bit wrap, no validity check
    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = c;
            if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
                nibble_of = c - ZERO_CHAR;
            end else begin
                if (c >= UPPER_A && c <= UPPER_Z) begin
                    v = c + CASE_DIFF;
                end
                nibble_of = v - LOWER_A + HEX_TEN;
            end
        end
    endfunction

endpackage

### src/pds_core.sv
module pds_core (
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  pds_pkg::pds_state_t cur,
    output pds_pkg::pds_state_t nxt,
    output pds_pkg::pds_result_t res
);
    import pds_pkg::*;

    logic [7:0] nib;
    logic [7:0] plain_data;
    logic       plain_valid;
    pds_phase_t plain_phase;

    assign nib = nibble_of(in_byte);

    // byte handled outside any escape
    always_comb begin
        plain_data  = 8'h00;
        plain_valid = 1'b0;
        plain_phase = PH_IDLE;
        if (in_byte == PLUS_CHAR) begin
            plain_data  = SPACE_CHAR;
            plain_valid = 1'b1;
        end else if (in_byte == PCT_CHAR || in_byte == NUL_CHAR) begin
            if (!in_last) begin
                plain_phase = PH_START;
            end
        end else begin
            plain_data  = in_byte;
            plain_valid = 1'b1;
        end
    end

    always_comb begin
        nxt.phase = PH_IDLE;
        nxt.held  = cur.held;
        res.data  = 8'h00;
        res.valid = 1'b0;
        res.last  = in_last;
        case (cur.phase)
            PH_DIGIT: begin
                // second nibble is not masked, it may reach the high bits
                res.data  = {cur.held[3:0], 4'h0} | nib;
                res.valid = 1'b1;
            end
            PH_START: begin
                if (!in_last) begin
                    nxt.held  = nib;
                    nxt.phase = PH_DIGIT;
                end else begin
                    // escape dropped, byte taken as plain
                    res.data  = plain_data;
                    res.valid = plain_valid;
                end
            end
            default: begin
                res.data  = plain_data;
                res.valid = plain_valid;
                nxt.phase = plain_phase;
            end
        endcase
        if (in_last) begin
            nxt.phase = PH_IDLE;
            nxt.held  = 8'h00;
        end
    end

endmodule

### src/percent_decode_stream.sv
// percent_decode_stream: streaming percent decoder, one encoded byte per request.
// input channel s_valid/s_ready carries s_in_byte and s_is_last (end of string).
// result channel m_valid/m_ready carries m_out_byte, m_byte_valid and m_out_last;
// every input request gives exactly one result request, in order.
// '+' becomes a space; '%' or a zero byte opens an escape and the next two bytes
// are merged as hex digits; an escape cut short by the end of string is dropped.
// m_out_byte is zero in every result whose m_byte_valid is low.
// an accepted request passes the input register, then the result register,
// before it shows on m_valid.
// throughput: one byte per cycle while the result side is not stalled; the
// escape state is updated in the single decode step between the two registers.
// reset (aresetn low, synchronous) empties both registers and clears the
// escape state; s_ready is high once reset has emptied the input register.
// when m_ready is low and a result waits, the result register holds and the
// input register takes one more request only if it is empty, then s_ready drops.
module percent_decode_stream (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_out_last
);
    import pds_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    pds_state_t  state_reg;
    pds_state_t  state_next;
    logic        out_valid_reg;
    pds_result_t out_reg;
    pds_result_t out_next;
    logic        advance;

    // the decode step moves when the result register is free or being taken
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    pds_core u_core (
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.phase <= PH_IDLE;
            state_reg.held  <= 8'h00;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_is_last;
        end
        if (advance && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_reg.data;
    assign m_byte_valid = out_reg.valid;
    assign m_out_last   = out_reg.last;

endmodule

### src/pds_checker.sv
`include "percent_decode_stream_assert.svh"

module pds_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_out_last
);

    // a result that was not taken stays put
    `PDS_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_byte_valid) && $stable(m_out_last), "stalled result changed")

    `PDS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid && s_ready, "pipeline not empty after reset")

    `PDS_ASSERT(a_no_byte_zero, m_valid && !m_byte_valid |-> m_out_byte == 8'h00, "dropped byte carries data")

    // a free output side never stalls the input
    `PDS_ASSERT(a_ready_pass, m_ready |-> s_ready, "input stalled while output drains")

endmodule

bind percent_decode_stream pds_checker u_pds_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_byte_valid (m_byte_valid),
    .m_out_last   (m_out_last)
);
